[hw/rtl/rdc_pkg.sv]
// Shared constants and payload types for the range distinct count block.
// Used by the top level; depends on nothing.
`timescale 1ns / 1ps

package rdc_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int VALUE_SPACE_DEF  = 1024;

    localparam int POS_W = 11;
    localparam int VAL_W = 10;
    localparam int CNT_W = 11;
    localparam int TAG_W = 16;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [POS_W-1:0] elem_index;
        logic [VAL_W-1:0] elem_value;
        logic [POS_W-1:0] left_bound;
        logic [POS_W-1:0] right_bound;
        logic [TAG_W-1:0] query_tag;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0] distinct_count;
        logic [TAG_W-1:0] answer_tag;
    } t_result;

endpackage

[hw/rtl/rdc_stream_if.sv]
// Valid/ready stream channel with a typed payload.
// Instantiated with the payload types of rdc_pkg.
`timescale 1ns / 1ps

interface rdc_stream_if #(
    parameter type t_payload = logic
);

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

[hw/rtl/range_distinct_count_window_top.sv]
// Top level of the range distinct count block: sequencer, window state and two RAMs.
// Depends on rdc_pkg, rdc_stream_if and rdc_ram.
`timescale 1ns / 1ps

// Items arrive on i_item; each is a load (mode 0) or a range query (mode 1).
// A load writes one element and produces no result. A query produces one
// result on o_result carrying the distinct value count and the query tag.
// After reset the value count table is cleared, one entry per cycle, and
// i_item.ready stays low during that pass. The block works on one item at a
// time. A load outside the current window only writes the element store; a
// load inside it also moves a count from the old value to the new one. A
// query moves the window edges one position at a time from the previous
// window to the requested range. Each move is an element read, then a
// dependent read-modify-write of the count memory. An empty query skips the
// walk and leaves the window as it is.
// Results sit in an output register, so the next item is accepted while a
// result waits. If the receiver stalls, a later query holds at its end until
// the output register frees up, and no item is accepted while it holds.

module range_distinct_count_window_top #(
    parameter int MAX_ELEMENTS = rdc_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_SPACE  = rdc_pkg::VALUE_SPACE_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rdc_stream_if.sink   i_item,
    rdc_stream_if.source o_result
);

    localparam int POS_W = rdc_pkg::POS_W;
    localparam int VAL_W = rdc_pkg::VAL_W;
    localparam int CNT_W = rdc_pkg::CNT_W;
    localparam int AW    = $clog2(MAX_ELEMENTS);
    localparam int CW    = $clog2(VALUE_SPACE);
    localparam int XAW   = (AW > POS_W) ? AW : POS_W;
    localparam int XCW   = (CW > VAL_W) ? CW : VAL_W;

    // Remainder by VALUE_SPACE through a reciprocal multiplication.
    localparam bit VS_WIDE = (VALUE_SPACE >= (1 << VAL_W));
    localparam int RSH     = VS_WIDE ? 0 : VAL_W + CW;
    localparam int RMUL    = VS_WIDE ? 1 : ((1 << RSH) + VALUE_SPACE - 1) / VALUE_SPACE;
    localparam int PW      = 2 * VAL_W + 2;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DISP = 3'd2;
    localparam logic [2:0] S_PLAN = 3'd3;
    localparam logic [2:0] S_VAL  = 3'd4;
    localparam logic [2:0] S_CRD  = 3'd5;
    localparam logic [2:0] S_UPD  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam logic [1:0] MV_LDEC = 2'd0;
    localparam logic [1:0] MV_RINC = 2'd1;
    localparam logic [1:0] MV_LINC = 2'd2;
    localparam logic [1:0] MV_RDEC = 2'd3;

    function automatic logic [VAL_W-1:0] mod_vs(input logic [VAL_W-1:0] v);
        logic [PW-1:0]    prod;
        logic [VAL_W-1:0] quot;
        logic [PW-1:0]    back;
        prod = PW'(v) * PW'(RMUL);
        quot = VAL_W'(prod >> RSH);
        back = PW'(quot) * PW'(VALUE_SPACE);
        if (VS_WIDE) begin
            return v;
        end
        return VAL_W'(PW'(v) - back);
    endfunction

    function automatic logic [CW-1:0] to_caddr(input logic [VAL_W-1:0] v);
        logic [XCW-1:0] x;
        x = XCW'(v);
        return x[CW-1:0];
    endfunction

    function automatic logic [AW-1:0] to_eaddr(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] p1;
        logic [XAW-1:0]   x;
        p1 = p - 1'b1;
        x  = XAW'(p1);
        return x[AW-1:0];
    endfunction

    logic [2:0]       r_state, n_state;
    logic [CW-1:0]    r_clr_addr, n_clr_addr;
    logic [POS_W-1:0] r_wl, n_wl;
    logic [POS_W-1:0] r_wr, n_wr;
    logic [CNT_W-1:0] r_total, n_total;
    rdc_pkg::t_item   r_item, n_item;
    logic [POS_W-1:0] r_ql, n_ql;
    logic [POS_W-1:0] r_qr, n_qr;
    logic [1:0]       r_move, n_move;
    logic [CW-1:0]    r_val, n_val;
    logic [VAL_W-1:0] r_newval, n_newval;
    logic             r_dir, n_dir;
    logic             r_load, n_load;
    logic             r_empty, n_empty;
    logic             r_out_valid, n_out_valid;
    rdc_pkg::t_result r_out, n_out;

    logic             e_we;
    logic [AW-1:0]    e_waddr;
    logic [VAL_W-1:0] e_wdata;
    logic [AW-1:0]    e_raddr;
    logic [VAL_W-1:0] e_rdata;
    logic             c_we;
    logic [CW-1:0]    c_waddr;
    logic [CNT_W-1:0] c_wdata;
    logic [CW-1:0]    c_raddr;
    logic [CNT_W-1:0] c_rdata;

    logic [POS_W-1:0] pos;
    logic             pos_ok;
    logic             in_window;
    logic [POS_W-1:0] ql_c;
    logic [POS_W-1:0] qr_c;
    logic [POS_W-1:0] step_pos;
    logic [1:0]       step_move;
    logic             walk_done;

    rdc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    rdc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (VALUE_SPACE)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    assign pos       = r_item.elem_index;
    assign pos_ok    = (pos != '0) && (32'(pos) <= MAX_ELEMENTS);
    assign in_window = (pos >= r_wl) && (pos <= r_wr);
    assign ql_c      = (r_item.left_bound == '0) ? POS_W'(1) : r_item.left_bound;
    assign qr_c      = (32'(r_item.right_bound) > MAX_ELEMENTS) ? POS_W'(MAX_ELEMENTS)
                                                               : r_item.right_bound;

    always_comb begin
        walk_done = 1'b0;
        step_move = MV_LDEC;
        step_pos  = r_wl - 1'b1;
        if (r_wl > r_ql) begin
            step_move = MV_LDEC;
            step_pos  = r_wl - 1'b1;
        end else if (r_wr < r_qr) begin
            step_move = MV_RINC;
            step_pos  = r_wr + 1'b1;
        end else if (r_wl < r_ql) begin
            step_move = MV_LINC;
            step_pos  = r_wl;
        end else if (r_wr > r_qr) begin
            step_move = MV_RDEC;
            step_pos  = r_wr;
        end else begin
            walk_done = 1'b1;
        end
    end

    assign i_item.ready     = (r_state == S_IDLE);
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_wl        = r_wl;
        n_wr        = r_wr;
        n_total     = r_total;
        n_item      = r_item;
        n_ql        = r_ql;
        n_qr        = r_qr;
        n_move      = r_move;
        n_val       = r_val;
        n_newval    = r_newval;
        n_dir       = r_dir;
        n_load      = r_load;
        n_empty     = r_empty;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        e_we    = 1'b0;
        e_waddr = to_eaddr(pos);
        e_wdata = mod_vs(r_item.elem_value);
        e_raddr = (r_state == S_DISP) ? to_eaddr(pos) : to_eaddr(step_pos);
        c_we    = 1'b0;
        c_waddr = (r_state == S_CLR) ? r_clr_addr : r_val;
        c_wdata = '0;
        c_raddr = (r_state == S_VAL) ? to_caddr(e_rdata) : r_val;

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                c_we       = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == CW'(VALUE_SPACE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_item.valid) begin
                    n_item  = i_item.payload;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_newval = mod_vs(r_item.elem_value);
                if (r_item.mode == rdc_pkg::MODE_LOAD) begin
                    if (!pos_ok) begin
                        n_state = S_IDLE;
                    end else if (in_window) begin
                        n_dir   = 1'b0;
                        n_load  = 1'b1;
                        n_state = S_VAL;
                    end else begin
                        e_we    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_ql    = ql_c;
                    n_qr    = qr_c;
                    n_load  = 1'b0;
                    n_empty = (ql_c > qr_c);
                    n_state = (ql_c > qr_c) ? S_DONE : S_PLAN;
                end
            end
            S_PLAN: begin
                if (walk_done) begin
                    n_state = S_DONE;
                end else begin
                    n_move  = step_move;
                    n_dir   = (step_move == MV_LDEC) || (step_move == MV_RINC);
                    n_state = S_VAL;
                end
            end
            S_VAL: begin
                n_val   = to_caddr(e_rdata);
                n_state = S_UPD;
            end
            S_CRD: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                c_we = 1'b1;
                if (r_dir) begin
                    c_wdata = c_rdata + 1'b1;
                    if (c_rdata == '0) begin
                        n_total = r_total + 1'b1;
                    end
                end else if (c_rdata != '0) begin
                    c_wdata = c_rdata - 1'b1;
                    if (c_rdata == CNT_W'(1)) begin
                        n_total = r_total - 1'b1;
                    end
                end
                if (r_load) begin
                    if (!r_dir) begin
                        e_we    = 1'b1;
                        e_wdata = r_newval;
                        n_val   = to_caddr(r_newval);
                        n_dir   = 1'b1;
                        n_state = S_CRD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    unique case (r_move)
                        MV_LDEC: n_wl = r_wl - 1'b1;
                        MV_RINC: n_wr = r_wr + 1'b1;
                        MV_LINC: n_wl = r_wl + 1'b1;
                        MV_RDEC: n_wr = r_wr - 1'b1;
                        default: n_wl = r_wl;
                    endcase
                    n_state = S_PLAN;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out.distinct_count = r_empty ? '0 : r_total;
                    n_out.answer_tag     = r_item.query_tag;
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_wl        <= POS_W'(1);
            r_wr        <= '0;
            r_total     <= '0;
            r_move      <= MV_LDEC;
            r_dir       <= 1'b0;
            r_load      <= 1'b0;
            r_empty     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_wl        <= n_wl;
            r_wr        <= n_wr;
            r_total     <= n_total;
            r_move      <= n_move;
            r_dir       <= n_dir;
            r_load      <= n_load;
            r_empty     <= n_empty;
            r_out_valid <= n_out_valid;
        end
        r_item   <= n_item;
        r_ql     <= n_ql;
        r_qr     <= n_qr;
        r_val    <= n_val;
        r_newval <= n_newval;
        r_out    <= n_out;
    end

`ifndef NO_ASSERTIONS
    a_window_formed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((POS_W + 1)'(r_wl) <= (POS_W + 1)'(r_wr) + 1'b1))
        else $error("Window left edge passed the right edge plus one.");

    a_total_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PLAN) |->
        ((POS_W + 1)'(r_total) + (POS_W + 1)'(r_wl) <= (POS_W + 1)'(r_wr) + 1'b1))
        else $error("Distinct total exceeds the window length.");

    a_window_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_empty) |-> (r_wl == r_ql && r_wr == r_qr))
        else $error("Query finished with the window off the requested range.");
`endif

endmodule

[hw/rtl/rdc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used for the element store and the value count table.
`timescale 1ns / 1ps

module rdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
